// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/pip_pkg.sv
package pip_pkg;

	localparam int COORD_W      = 24;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int DIST_W       = PROD_W + 1;
	localparam int AREA_W       = 62;
	localparam int MAX_VERTICES = 1024;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int CFG_IDX_W    = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = CFG_IDX_W'(1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	// vertex as registered at the input stage
	typedef struct packed {
		coord_t           vx;
		coord_t           vy;
		coord_t           px;
		coord_t           py;
		coord_t           fx;
		coord_t           fy;
		logic [IDX_W-1:0] idx;
		logic             first_vtx;
		logic             in_range;
		logic             last;
		logic             ge3;
	} s1_t;

	// per-edge products for the crossing test and the shoelace term
	typedef struct packed {
		prod_t lhs;
		prod_t rhs;
		prod_t area;
		logic  straddle;
		logic  dypos;
	} seg_t;

	// registered products
	typedef struct packed {
		seg_t             e;
		seg_t             c;
		prod_t            sq_x;
		prod_t            sq_y;
		logic [IDX_W-1:0] idx;
		logic             first_vtx;
		logic             in_range;
		logic             last;
		logic             ge3;
	} s2_t;

	function automatic seg_t seg_terms(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
			coord_t qx, coord_t qy);
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] qdx;
		logic signed [DIFF_W-1:0] qdy;
		logic signed [DIFF_W-1:0] ysum;
		seg_t r;
		dy   = DIFF_W'(y2) - DIFF_W'(y1);
		dx   = DIFF_W'(x2) - DIFF_W'(x1);
		qdx  = DIFF_W'(qx) - DIFF_W'(x1);
		qdy  = DIFF_W'(qy) - DIFF_W'(y1);
		ysum = DIFF_W'(y2) + DIFF_W'(y1);
		r.lhs      = PROD_W'(qdx) * PROD_W'(dy);
		r.rhs      = PROD_W'(dx) * PROD_W'(qdy);
		r.area     = PROD_W'(dx) * PROD_W'(ysum);
		r.straddle = (y1 > qy) != (y2 > qy);
		r.dypos    = !dy[DIFF_W-1] && (dy != '0);
		return r;
	endfunction

endpackage

// File: sv/pip_front.sv
module pip_front
	import pip_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  coord_t vertex_x,
	input  coord_t vertex_y,
	input  logic   last_vertex,
	input  logic   in_valid,
	output logic   in_ready,
	input  logic   s1_take,
	output logic   s1_valid,
	output s1_t    s1
);

	logic             accept;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_inc;
	logic             first_vtx;
	coord_t           prev_x_q, prev_y_q, first_x_q, first_y_q;
	logic             s1_valid_q;

	assign in_ready  = !s1_valid_q || s1_take;
	assign accept    = in_valid && in_ready;
	assign first_vtx = (count_q == '0);
	assign count_inc = (count_q < CNT_W'(MAX_VERTICES)) ? count_q + CNT_W'(1) : count_q;

	// vertex count and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= last_vertex ? '0 : count_inc;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_take) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// previous and first vertex, input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q <= vertex_x;
			prev_y_q <= vertex_y;
			if (first_vtx) begin
				first_x_q <= vertex_x;
				first_y_q <= vertex_y;
			end
			s1.vx        <= vertex_x;
			s1.vy        <= vertex_y;
			s1.px        <= prev_x_q;
			s1.py        <= prev_y_q;
			s1.fx        <= first_vtx ? vertex_x : first_x_q;
			s1.fy        <= first_vtx ? vertex_y : first_y_q;
			s1.idx       <= count_q[IDX_W-1:0];
			s1.first_vtx <= first_vtx;
			s1.in_range  <= count_q < CNT_W'(MAX_VERTICES);
			s1.last      <= last_vertex;
			s1.ge3       <= count_inc >= CNT_W'(3);
		end
	end

	assign s1_valid = s1_valid_q;

endmodule

// File: sv/pip_mult.sv
module pip_mult
	import pip_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  coord_t qx,
	input  coord_t qy,
	input  logic   s1_valid,
	input  s1_t    s1,
	input  logic   s2_take,
	output logic   s2_valid,
	output s2_t    s2
);

	logic signed [DIFF_W-1:0] ddx, ddy;
	seg_t                     seg_e, seg_c;

	// edge from previous vertex, and closing edge back to the first
	assign seg_e = seg_terms(s1.px, s1.py, s1.vx, s1.vy, qx, qy);
	assign seg_c = seg_terms(s1.vx, s1.vy, s1.fx, s1.fy, qx, qy);
	assign ddx   = DIFF_W'(s1.vx) - DIFF_W'(qx);
	assign ddy   = DIFF_W'(s1.vy) - DIFF_W'(qy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s2_take) begin
			s2_valid <= s1_valid;
		end
	end

	// product register
	always_ff @(posedge clk) begin
		if (s2_take && s1_valid) begin
			s2.e         <= seg_e;
			s2.c         <= seg_c;
			s2.sq_x      <= PROD_W'(ddx) * PROD_W'(ddx);
			s2.sq_y      <= PROD_W'(ddy) * PROD_W'(ddy);
			s2.idx       <= s1.idx;
			s2.first_vtx <= s1.first_vtx;
			s2.in_range  <= s1.in_range;
			s2.last      <= s1.last;
			s2.ge3       <= s1.ge3;
		end
	end

endmodule

// File: sv/pip_accum.sv
module pip_accum
	import pip_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s2_valid,
	input  s2_t              s2,
	output logic             s2_take,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             inside_res,
	output logic             counter_clockwise,
	output logic             orientation_valid,
	output logic [IDX_W-1:0] closest_index
);

	logic              parity_q;
	logic [AREA_W-1:0] area_q;
	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              out_valid_q;

	logic              out_free, fire;
	logic              cross_e, cross_c, parity_new;
	logic [AREA_W-1:0] area_e, area_c, area_new;
	logic [DIST_W-1:0] vtx_dist;
	logic              take_best;
	logic [DIST_W-1:0] best_new;
	logic [IDX_W-1:0]  best_idx_new;

	// a last vertex waits while the result register is occupied and out_ready is low
	assign out_free = !out_valid_q || out_ready;
	assign fire     = s2_valid && (!s2.last || out_free);
	assign s2_take  = !s2_valid || fire;

	// crossing parity, comparison flipped when dy is negative
	assign cross_e = !s2.first_vtx && s2.e.straddle &&
		(s2.e.dypos ? (s2.e.lhs < s2.e.rhs) : (s2.e.rhs < s2.e.lhs));
	assign cross_c = s2.last && s2.c.straddle &&
		(s2.c.dypos ? (s2.c.lhs < s2.c.rhs) : (s2.c.rhs < s2.c.lhs));
	assign parity_new = parity_q ^ cross_e ^ cross_c;

	// shoelace sum, wraps at its width
	assign area_e   = s2.first_vtx ? '0 : AREA_W'(s2.e.area);
	assign area_c   = s2.last ? AREA_W'(s2.c.area) : '0;
	assign area_new = area_q + area_e + area_c;

	// nearest vertex, earliest index wins ties
	assign vtx_dist     = DIST_W'($unsigned(s2.sq_x)) + DIST_W'($unsigned(s2.sq_y));
	assign take_best    = s2.first_vtx || (s2.in_range && (vtx_dist < best_q));
	assign best_new     = take_best ? vtx_dist : best_q;
	assign best_idx_new = s2.first_vtx ? '0 : (take_best ? s2.idx : best_idx_q);

	// running results, cleared once a polygon closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q   <= 1'b0;
			area_q     <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (fire) begin
			if (s2.last) begin
				parity_q   <= 1'b0;
				area_q     <= '0;
				best_q     <= '0;
				best_idx_q <= '0;
			end else begin
				parity_q   <= parity_new;
				area_q     <= area_new;
				best_q     <= best_new;
				best_idx_q <= best_idx_new;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && s2.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && s2.last) begin
			inside_res        <= parity_new;
			counter_clockwise <= area_new[AREA_W-1];
			orientation_valid <= s2.ge3;
			closest_index     <= best_idx_new;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: sv/polygon_inside_orientation_closest.sv
// Point-in-polygon test, orientation and nearest vertex over a vertex stream.
// Input channel (in_valid/in_ready): one vertex per transfer, signed Q12.12
// vertex_x/vertex_y, last_vertex high on the final vertex of a polygon.
// Output channel (out_valid/out_ready): one result per polygon, on its last
// vertex: inside_res (odd crossing count), counter_clockwise (shoelace sum
// negative), orientation_valid (three or more vertices), closest_index.
// Query point comes from the write port: cfg_we with cfg_index 0 (x) or 1 (y);
// other indexes are ignored. Write it only between polygons.
// Throughput: one vertex per cycle while no last vertex waits for the result
// register. Three register stages (vertex register, product register,
// accumulators with result register) lie between a last vertex and its result.
// A stalled result holds the result register; vertices that are not last keep
// flowing into the accumulators, and only a last vertex waits for the result
// register to free, which then back-pressures in_ready.
// Reset clears the query point, the vertex count, the running results and both
// channels' valid flags; the block is ready as soon as reset is released.
// Vertices past the 1024th still count for parity and area but cannot be closest.
module polygon_inside_orientation_closest
	import pip_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  coord_t               vertex_x,
	input  coord_t               vertex_y,
	input  logic                 last_vertex,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 inside_res,
	output logic                 counter_clockwise,
	output logic                 orientation_valid,
	output logic [IDX_W-1:0]     closest_index,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);

	coord_t query_x_q, query_y_q;
	logic   s1_valid, s2_valid, s2_take;
	s1_t    s1;
	s2_t    s2;

	// query point registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUERY_X: query_x_q <= cfg_data;
				REG_QUERY_Y: query_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pip_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.last_vertex (last_vertex),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.s1_take     (s2_take),
		.s1_valid    (s1_valid),
		.s1          (s1)
	);

	pip_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.qx       (query_x_q),
		.qy       (query_y_q),
		.s1_valid (s1_valid),
		.s1       (s1),
		.s2_take  (s2_take),
		.s2_valid (s2_valid),
		.s2       (s2)
	);

	pip_accum u_accum (
		.clk               (clk),
		.arst_n            (arst_n),
		.s2_valid          (s2_valid),
		.s2                (s2),
		.s2_take           (s2_take),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.inside_res        (inside_res),
		.counter_clockwise (counter_clockwise),
		.orientation_valid (orientation_valid),
		.closest_index     (closest_index)
	);

endmodule

// File: sv/pip_checker.sv
`include "assert_macros.svh"

module pip_checker
	import pip_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic             inside_res,
	input logic             counter_clockwise,
	input logic             orientation_valid,
	input logic [IDX_W-1:0] closest_index
);

	// a stalled result stays offered
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// a stalled result keeps its fields
	`ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
		$stable(closest_index) && $stable(inside_res) && $stable(counter_clockwise) && $stable(orientation_valid),
		"result changed while stalled")

	// a closest index of two or more means the polygon had three or more vertices
	`ASSERT_IMPL(a_idx_valid, out_valid && (closest_index > IDX_W'(1)), orientation_valid,
		"closest index beyond vertex count")

endmodule

bind polygon_inside_orientation_closest pip_checker u_pip_checker (.*);
